### rtl/core/apa_wfg_pkg.sv
// ============================================================================
// APA102 wheel frame generator package
// Shared types, constants and the color wheel function.
// ============================================================================
package apa_wfg_pkg;

    localparam int NUM_LEDS_DEFAULT = 3;
    localparam int CQ_DEPTH         = 2;

    localparam logic [1:0] ACT_SHOW  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [7:0] START_BYTE = 8'h00;
    localparam logic [7:0] END_BYTE   = 8'hFF;
    localparam logic [7:0] HDR_BASE   = 8'hE0;

    localparam logic [4:0] BRIGHT_RESET = 5'd1;
    localparam logic [7:0] WHEEL_RESET  = 8'd254;

    typedef struct packed {
        logic [23:0] color;
        logic        one_only;
        logic [1:0]  sel;
    } cmd_t;

    function automatic logic [23:0] hue_rgb(input logic [7:0] pos);
        logic [7:0] p;
        logic [7:0] q;
        logic [9:0] t;
        logic [7:0] up;
        logic [7:0] dn;
        p = 8'd255 - pos;
        if (p < 8'd85)
        begin
            q = p;
        end
        else if (p < 8'd170)
        begin
            q = p - 8'd85;
        end
        else
        begin
            q = p - 8'd170;
        end
        t  = {2'b00, q} * 10'd3;
        up = t[7:0];
        dn = 8'd255 - up;
        if (p < 8'd85)
        begin
            hue_rgb = {dn, 8'h00, up};
        end
        else if (p < 8'd170)
        begin
            hue_rgb = {8'h00, up, dn};
        end
        else
        begin
            hue_rgb = {up, dn, 8'h00};
        end
    endfunction

endpackage

### rtl/core/apa102_wheel_frame_generator_unit.sv
// ============================================================================
// APA102 wheel frame generator
// Turns show, start and tick commands into APA102 LED strip byte streams.
// ============================================================================
//
//   Channel   Handshake           Payload
//   -------   -----------------   ------------------------------
//   command   push / full         action, color, led_index
//   bytes     pop / empty         spi_byte, last
//   config    cfg_valid / ready   cfg_data (brightness)
//
// A frame carries 8 + 4 * NUM_LEDS bytes, 20 with three LEDs, and the byte engine
// emits one per cycle unless a held output byte is not popped; consecutive frames
// follow without a gap. Commands that make no frame never enter the queue.
// A two-entry command queue lets commands be taken while a frame is still
// going out; full rises only when both entries wait. Reset clears the queue
// and output stage, sets brightness to 1, wheel position to 254, rainbow off.
//
module apa102_wheel_frame_generator_unit
#(
    parameter int NUM_LEDS = apa_wfg_pkg::NUM_LEDS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [23:0] color,
    input  logic [1:0]  led_index,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  spi_byte,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import apa_wfg_pkg::*;

    logic [4:0] brightness_reg;
    logic [4:0] brightness_next;
    logic       accept;
    logic       cq_wr;
    cmd_t       cq_wdata;
    logic       cq_rd;
    cmd_t       cq_rdata;
    logic       cq_full;
    logic       cq_nonempty;

    assign cfg_ready = 1'b1;
    assign full      = cq_full;
    assign accept    = push && !cq_full;

    always_comb
    begin
        brightness_next = brightness_reg;
        if (cfg_valid && cfg_ready)
        begin
            brightness_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHT_RESET;
        end
        else
        begin
            brightness_reg <= brightness_next;
        end
    end

    apa_wfg_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (action),
        .color     (color),
        .led_index (led_index),
        .cq_wr     (cq_wr),
        .cq_wdata  (cq_wdata)
    );

    apa_wfg_cmdq u_cmdq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (cq_wr),
        .wdata    (cq_wdata),
        .rd       (cq_rd),
        .rdata    (cq_rdata),
        .full     (cq_full),
        .nonempty (cq_nonempty)
    );

    apa_wfg_back #(
        .NUM_LEDS (NUM_LEDS)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .brightness  (brightness_reg),
        .cq_nonempty (cq_nonempty),
        .cq_rdata    (cq_rdata),
        .cq_rd       (cq_rd),
        .empty       (empty),
        .pop         (pop),
        .spi_byte    (spi_byte),
        .last        (last)
    );

    // The final byte of every frame is an end byte.
    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (spi_byte == END_BYTE))
        else $error("last byte is not an end byte");

    // The front end never writes into a full command queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cq_wr |-> !cq_full)
        else $error("command queue overflow");

    // The byte engine only takes commands that are present.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cq_rd |-> cq_nonempty)
        else $error("command queue underflow");

endmodule

### rtl/core/apa_wfg_front.sv
// ============================================================================
// APA102 wheel frame generator front end
// Decodes commands, tracks rainbow mode and wheel position, queues frames.
// ============================================================================
module apa_wfg_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          action,
    input  logic [23:0]         color,
    input  logic [1:0]          led_index,
    output logic                cq_wr,
    output apa_wfg_pkg::cmd_t   cq_wdata
);
    import apa_wfg_pkg::*;

    logic [7:0] wheel_pos_reg;
    logic [7:0] wheel_pos_next;
    logic       rainbow_reg;
    logic       rainbow_next;

    always_comb
    begin
        wheel_pos_next = wheel_pos_reg;
        rainbow_next   = rainbow_reg;
        cq_wr          = 1'b0;
        cq_wdata       = '{color: color, one_only: 1'b1, sel: led_index};
        if (accept)
        begin
            case (action)
                ACT_SHOW:
                begin
                    rainbow_next = 1'b0;
                    cq_wr        = 1'b1;
                end
                ACT_START:
                begin
                    rainbow_next = 1'b1;
                end
                ACT_TICK:
                begin
                    if (rainbow_reg)
                    begin
                        cq_wr          = 1'b1;
                        cq_wdata       = '{color: hue_rgb(wheel_pos_reg),
                                           one_only: 1'b0, sel: 2'd0};
                        wheel_pos_next = wheel_pos_reg - 8'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_pos_reg <= WHEEL_RESET;
            rainbow_reg   <= 1'b0;
        end
        else
        begin
            wheel_pos_reg <= wheel_pos_next;
            rainbow_reg   <= rainbow_next;
        end
    end

endmodule

### rtl/core/apa_wfg_cmdq.sv
// ============================================================================
// APA102 wheel frame generator command queue
// Short FIFO of frame commands between the front end and the byte engine.
// ============================================================================
module apa_wfg_cmdq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  apa_wfg_pkg::cmd_t   wdata,
    input  logic                rd,
    output apa_wfg_pkg::cmd_t   rdata,
    output logic                full,
    output logic                nonempty
);
    import apa_wfg_pkg::*;

    localparam int AW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CW = $clog2(CQ_DEPTH + 1);

    cmd_t            mem_reg [CQ_DEPTH];
    logic [AW-1:0]   wptr_reg;
    logic [AW-1:0]   wptr_next;
    logic [AW-1:0]   rptr_reg;
    logic [AW-1:0]   rptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign rdata    = mem_reg[rptr_reg];
    assign full     = (count_reg == CW'(CQ_DEPTH));
    assign nonempty = (count_reg != '0);

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (wr)
        begin
            wptr_next = (wptr_reg == AW'(CQ_DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
        end
        if (rd)
        begin
            rptr_next = (rptr_reg == AW'(CQ_DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
        end
        if (wr && !rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/core/apa_wfg_back.sv
// ============================================================================
// APA102 wheel frame generator byte engine
// Expands a frame command into serial bytes, one per cycle unless pop stalls.
// ============================================================================
module apa_wfg_back
#(
    parameter int NUM_LEDS = apa_wfg_pkg::NUM_LEDS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [4:0]          brightness,
    input  logic                cq_nonempty,
    input  apa_wfg_pkg::cmd_t   cq_rdata,
    output logic                cq_rd,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          spi_byte,
    output logic                last
);
    import apa_wfg_pkg::*;

    localparam int FRAME_LEN = 8 + 4 * NUM_LEDS;
    localparam int CW        = $clog2(FRAME_LEN + 1);
    localparam int LED_BASE  = 4;
    localparam int END_BASE  = 4 + 4 * NUM_LEDS;

    localparam logic [1:0] SUB_HDR   = 2'd0;
    localparam logic [1:0] SUB_BLUE  = 2'd1;
    localparam logic [1:0] SUB_GREEN = 2'd2;
    localparam logic [1:0] SUB_RED   = 2'd3;

    cmd_t          cmd_reg;
    cmd_t          cmd_next;
    logic          busy_reg;
    logic          busy_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_byte_reg;
    logic [7:0]    out_byte_next;
    logic          out_last_reg;
    logic          out_last_next;

    logic          pop_ok;
    logic          adv;
    logic          at_end;
    logic          load;
    logic [CW-1:0] idx;
    logic [CW-1:0] led;
    logic          lit;
    logic [23:0]   v;
    logic [7:0]    byte_sel;

    assign pop_ok   = pop && out_valid_reg;
    assign adv      = busy_reg && (!out_valid_reg || pop);
    assign at_end   = (cnt_reg == CW'(FRAME_LEN - 1));
    assign load     = cq_nonempty && (!busy_reg || (adv && at_end));
    assign cq_rd    = load;

    assign empty    = !out_valid_reg;
    assign spi_byte = out_byte_reg;
    assign last     = out_last_reg;

    always_comb
    begin
        idx = cnt_reg - CW'(LED_BASE);
        led = idx >> 2;
        lit = !cmd_reg.one_only || (led == CW'(cmd_reg.sel));
        v   = lit ? cmd_reg.color : 24'h000000;
        if (cnt_reg < CW'(LED_BASE))
        begin
            byte_sel = START_BYTE;
        end
        else if (cnt_reg >= CW'(END_BASE))
        begin
            byte_sel = END_BYTE;
        end
        else
        begin
            case (idx[1:0])
                SUB_HDR:   byte_sel = HDR_BASE | {3'b000, brightness};
                SUB_BLUE:  byte_sel = v[7:0];
                SUB_GREEN: byte_sel = v[15:8];
                SUB_RED:   byte_sel = v[23:16];
                default:   byte_sel = START_BYTE;
            endcase
        end
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = byte_sel;
            out_last_next  = at_end;
            cnt_next       = cnt_reg + CW'(1);
            if (at_end)
            begin
                busy_next = 1'b0;
            end
        end
        else if (pop_ok)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            cmd_next  = cq_rdata;
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### tb/tb.sv
// ============================================================================
// APA102 wheel frame generator testbench
// Drives show, start, tick and unused commands into the command port,
// predicts every serial byte of every frame, and compares each popped byte
// and its last flag in order. Brightness is rewritten between phases while
// the block is idle.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apa_wfg_pkg::*;

    localparam int         NUM_LEDS   = 3;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         SETTLE_CYC = 40;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } led_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  action = ACT_SHOW;
    logic [23:0] color = '0;
    logic [1:0]  led_index = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  spi_byte;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    led_byte_t   pending_bytes[$];
    led_byte_t   oldest;
    logic [4:0]  bright_now = BRIGHT_RESET;
    logic [7:0]  wheel_pos = WHEEL_RESET;
    logic        rainbow_on = 1'b0;

    int          errors = 0;
    int          cmds_sent = 0;
    int          bytes_seen = 0;
    int          frames_seen = 0;
    int          burst_left = 4;
    bit          gaps_on = 1'b1;
    int          pop_mode = 0;
    int          pop_cnt = 0;

    apa102_wheel_frame_generator_unit #(.NUM_LEDS(NUM_LEDS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .color     (color),
        .led_index (led_index),
        .empty     (empty),
        .pop       (pop),
        .spi_byte  (spi_byte),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
        int p;
        int r;
        int g;
        int b;
        p = 255 - int'(pos);
        if (p < 85)
        begin
            r = 255 - 3 * p;
            g = 0;
            b = 3 * p;
        end
        else if (p < 170)
        begin
            r = 0;
            g = 3 * (p - 85);
            b = 255 - 3 * (p - 85);
        end
        else
        begin
            r = 3 * (p - 170);
            g = 255 - 3 * (p - 170);
            b = 0;
        end
        return {r[7:0], g[7:0], b[7:0]};
    endfunction

    task automatic add_byte(input logic [7:0] data, input logic is_last);
        led_byte_t item;
        item.data = data;
        item.last = is_last;
        pending_bytes.push_back(item);
    endtask

    task automatic expect_frame(input logic [23:0] rgb, input logic one_only,
                                input logic [1:0] sel);
        logic [23:0] v;
        for (int i = 0; i < 4; i++)
            add_byte(START_BYTE, 1'b0);
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            v = (!one_only || i == int'(sel)) ? rgb : 24'h0;
            add_byte(HDR_BASE | {3'b000, bright_now}, 1'b0);
            add_byte(v[7:0], 1'b0);
            add_byte(v[15:8], 1'b0);
            add_byte(v[23:16], 1'b0);
        end
        for (int i = 0; i < 4; i++)
            add_byte(END_BYTE, i == 3);
    endtask

    task automatic predict_command(input logic [1:0] a, input logic [23:0] c,
                                   input logic [1:0] l);
        case (a)
            ACT_SHOW:
            begin
                rainbow_on = 1'b0;
                expect_frame(c, 1'b1, l);
            end
            ACT_START:
                rainbow_on = 1'b1;
            ACT_TICK:
                if (rainbow_on)
                begin
                    expect_frame(wheel_rgb(wheel_pos), 1'b0, 2'd0);
                    wheel_pos = wheel_pos - 8'd1;
                end
            default:
                ;
        endcase
    endtask

    task automatic send_item(input logic [1:0] a, input logic [23:0] c,
                             input logic [1:0] l);
        int gap;
        @(negedge clk);
        push      <= 1'b1;
        action    <= a;
        color     <= c;
        led_index <= l;
        do
            @(posedge clk);
        while (full);
        predict_command(a, c, l);
        cmds_sent++;
        if (gaps_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 10);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    @(negedge clk);
                    push <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    endtask

    task automatic drain_and_settle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_brightness(input logic [4:0] value);
        drain_and_settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        bright_now = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_item(ACT_TICK, 24'h000000, 2'd0);
        send_item(ACT_SHOW, 24'hFF0000, 2'd0);
    endtask

    task automatic test_show();
        write_brightness(5'd31);
        send_item(ACT_SHOW, 24'h000000, 2'd0);
        send_item(ACT_SHOW, 24'hFFFFFF, 2'd2);
        send_item(ACT_SHOW, 24'hA5C35A, 2'd1);
        send_item(ACT_SHOW, 24'h5A3CA5, 2'd0);
        send_item(ACT_SHOW, 24'hFFFFFF, 2'd3);
    endtask

    task automatic test_ignored_commands();
        send_item(ACT_UNUSED, 24'hFFFFFF, 2'd3);
        send_item(ACT_TICK, 24'h123456, 2'd1);
        send_item(ACT_UNUSED, 24'h000000, 2'd0);
    endtask

    task automatic test_rainbow();
        send_item(ACT_START, 24'hFFFFFF, 2'd2);
        send_item(ACT_TICK, 24'hFFFFFF, 2'd3);
        send_item(ACT_TICK, 24'h000000, 2'd0);
        send_item(ACT_UNUSED, 24'h00FF00, 2'd1);
        send_item(ACT_SHOW, 24'h00FF00, 2'd1);
        send_item(ACT_TICK, 24'h000000, 2'd0);
        send_item(ACT_START, 24'h000000, 2'd0);
        send_item(ACT_START, 24'h000000, 2'd0);
        write_brightness(5'd0);
        send_item(ACT_TICK, 24'h000000, 2'd0);
        send_item(ACT_SHOW, 24'h123456, 2'd1);
    endtask

    task automatic test_wheel_sweep();
        write_brightness(5'($urandom_range(0, 31)));
        send_item(ACT_START, 24'($urandom_range(0, 24'hFFFFFF)), 2'($urandom_range(0, 3)));
        for (int i = 0; i < 256; i++)
            send_item(ACT_TICK, 24'($urandom_range(0, 24'hFFFFFF)), 2'($urandom_range(0, 3)));
    endtask

    task automatic test_random_mix();
        logic [4:0]  levels[4];
        logic [1:0]  a;
        int          r;
        levels = '{5'd31, 5'd0, 5'($urandom_range(0, 31)), 5'd16};
        for (int phase = 0; phase < 4; phase++)
        begin
            write_brightness(levels[phase]);
            gaps_on = (phase != 2);
            for (int i = 0; i < 18; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    a = ACT_TICK;
                else if (r < 72)
                    a = ACT_SHOW;
                else if (r < 88)
                    a = ACT_START;
                else
                    a = ACT_UNUSED;
                send_item(a, 24'($urandom_range(0, 24'hFFFFFF)),
                          2'($urandom_range(0, 3)));
            end
        end
        gaps_on = 1'b1;
        write_brightness(BRIGHT_RESET);
        send_item(ACT_START, 24'h0, 2'd0);
        send_item(ACT_TICK, 24'h0, 2'd0);
    endtask

    always @(negedge clk)
    begin
        pop_cnt++;
        if (pop_cnt % 150 == 0)
            pop_mode = $urandom_range(0, 3);
        case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= (pop_cnt % 8 < 5);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected byte: spi_byte %02h last %0b", spi_byte, last);
                errors++;
            end
            else
            begin
                oldest = pending_bytes.pop_front();
                if (spi_byte !== oldest.data)
                begin
                    $error("spi_byte: expected %02h, actual %02h", oldest.data, spi_byte);
                    errors++;
                end
                if (last !== oldest.last)
                begin
                    $error("last: expected %0b, actual %0b", oldest.last, last);
                    errors++;
                end
                bytes_seen++;
                if (oldest.last)
                    frames_seen++;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_show();
        test_ignored_commands();
        test_rainbow();
        test_wheel_sweep();
        test_random_mix();
        drain_and_settle();
        if (pending_bytes.size() != 0)
        begin
            $error("%0d expected bytes never arrived", pending_bytes.size());
            errors++;
        end
        $display("Sent %0d commands; checked %0d bytes in %0d frames.",
                 cmds_sent, bytes_seen, frames_seen);
        $display("Covered a full wheel sweep, shows on every LED index and brightness 0 to 31.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/apa_wfg_pkg.sv
rtl/core/apa_wfg_front.sv
rtl/core/apa_wfg_cmdq.sv
rtl/core/apa_wfg_back.sv
rtl/core/apa102_wheel_frame_generator_unit.sv
tb/tb.sv
